/* rtl/core/vmod_pkg.sv */
// Shared types, codes and decode functions for the operand mode decoder.
`default_nettype none
package vmod_pkg;

  localparam logic [3:0] MAX_OPERANDS = 4'd8;
  localparam logic [3:0] MODE_MASK    = 4'hF;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [2:0] CLS_CONST     = 3'd0;
  localparam logic [2:0] CLS_POP       = 3'd1;
  localparam logic [2:0] CLS_MEM_LOAD  = 3'd2;
  localparam logic [2:0] CLS_LOC_LOAD  = 3'd3;
  localparam logic [2:0] CLS_DISCARD   = 3'd4;
  localparam logic [2:0] CLS_PUSH      = 3'd5;
  localparam logic [2:0] CLS_MEM_STORE = 3'd6;
  localparam logic [2:0] CLS_LOC_STORE = 3'd7;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_LOAD  = 2'd1;
  localparam logic [1:0] FLT_STORE = 2'd2;

  localparam logic [3:0] MODE_ZERO    = 4'd0;
  localparam logic [3:0] MODE_BAD_LO  = 4'd4;
  localparam logic [3:0] MODE_STACK   = 4'd8;
  localparam logic [3:0] MODE_BAD_HI  = 4'd12;

  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] ADDR_RAM_START = 3'd0;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MODES = 2'd1,
    PH_BYTES = 2'd2,
    PH_ADV   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    W_ZERO  = 3'd0,
    W_SX8   = 3'd1,
    W_SX16  = 3'd2,
    W_RAW   = 3'd3,
    W_LOCAL = 3'd4,
    W_RAM   = 3'd5
  } wsel_t;

  typedef struct packed {
    logic [2:0] cls;
    wsel_t      wsel;
    logic [1:0] fault;
  } dec_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [2:0]  cls;
    wsel_t       wsel;
    logic [31:0] acc;
    logic [31:0] base;
    logic [1:0]  size;
    logic [1:0]  fault;
    logic        last;
  } job_t;

  function automatic logic is_bad(input logic [3:0] mode, input logic store);
    is_bad = (mode == MODE_BAD_LO) || (mode == MODE_BAD_HI) ||
             (store && (mode != MODE_ZERO) && (mode < MODE_BAD_LO));
  endfunction

  function automatic logic [2:0] bytes_for(input logic [3:0] mode, input logic store);
    if ((mode[1:0] == 2'd0) || is_bad(mode, store)) begin
      bytes_for = 3'd0;
    end else if (mode[1:0] == 2'd3) begin
      bytes_for = 3'd4;
    end else begin
      bytes_for = {1'b0, mode[1:0]};
    end
  endfunction

  function automatic dec_t decode(input logic [3:0] mode, input logic store);
    dec_t d;
    d.cls   = CLS_CONST;
    d.wsel  = W_ZERO;
    d.fault = FLT_NONE;
    if (is_bad(mode, store)) begin
      d.fault = store ? FLT_STORE : FLT_LOAD;
    end else if (!store) begin
      if (mode == MODE_ZERO) begin
        d.cls = CLS_CONST;
      end else if (mode < MODE_BAD_LO) begin
        d.cls = CLS_CONST;
        case (mode[1:0])
          2'd1:    d.wsel = W_SX8;
          2'd2:    d.wsel = W_SX16;
          default: d.wsel = W_RAW;
        endcase
      end else if (mode == MODE_STACK) begin
        d.cls = CLS_POP;
      end else if (mode < MODE_STACK) begin
        d.cls  = CLS_MEM_LOAD;
        d.wsel = W_RAW;
      end else if (mode < MODE_BAD_HI) begin
        d.cls  = CLS_LOC_LOAD;
        d.wsel = W_LOCAL;
      end else begin
        d.cls  = CLS_MEM_LOAD;
        d.wsel = W_RAM;
      end
    end else begin
      if (mode == MODE_ZERO) begin
        d.cls = CLS_DISCARD;
      end else if (mode == MODE_STACK) begin
        d.cls = CLS_PUSH;
      end else if (mode < MODE_STACK) begin
        d.cls  = CLS_MEM_STORE;
        d.wsel = W_RAW;
      end else if (mode < MODE_BAD_HI) begin
        d.cls  = CLS_LOC_STORE;
        d.wsel = W_RAW;
      end else begin
        d.cls  = CLS_MEM_STORE;
        d.wsel = W_RAM;
      end
    end
    decode = d;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/vmod_if.sv */
// Input and result channel interfaces of the operand mode decoder.
`default_nettype none
interface vmod_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  operand_count;
  logic [1:0]  size_code;
  logic [7:0]  store_mask;
  logic [31:0] locals_base;
  logic [7:0]  code_byte;

  modport source (
    output valid, kind, operand_count, size_code, store_mask, locals_base, code_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, operand_count, size_code, store_mask, locals_base, code_byte,
    output ready
  );
endinterface

interface vmod_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operand_index;
  logic [2:0]  operand_class;
  logic [31:0] operand_word;
  logic [1:0]  access_size;
  logic [1:0]  fault;
  logic        last;

  modport source (
    output valid, operand_index, operand_class, operand_word, access_size, fault, last,
    input  ready
  );
  modport sink (
    input  valid, operand_index, operand_class, operand_word, access_size, fault, last,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/core/vmod_front.sv */
// Front sequencer: takes start and byte items, stores mode nibbles, queues descriptors.
`default_nettype none
module vmod_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  vmod_in_if.sink            in_ch,
  input  wire logic          q_full,
  output logic               q_push,
  output vmod_pkg::job_t     q_job
);

  vmod_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  ops_r, ops_nxt;
  logic [1:0]  size_r, size_nxt;
  logic [7:0]  form_r, form_nxt;
  logic [31:0] base_r, base_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [3:0]  cur_r, cur_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  nib_r [8];

  logic          in_fire;
  logic          nib_we;
  logic [31:0]   acc_in;
  logic [3:0]    mode_cur;
  logic          store_cur;
  vmod_pkg::dec_t dec;
  logic          last_cur;
  logic [2:0]    k_cur;

  assign in_ch.ready = (phase_r != vmod_pkg::PH_ADV) && !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign acc_in      = {acc_r[23:0], in_ch.code_byte};
  assign mode_cur    = nib_r[cur_r[2:0]];
  assign store_cur   = form_r[cur_r[2:0]];
  assign dec         = vmod_pkg::decode(mode_cur, store_cur);
  assign k_cur       = vmod_pkg::bytes_for(mode_cur, store_cur);
  assign last_cur    = (dec.fault != vmod_pkg::FLT_NONE) ||
                       (({1'b0, cur_r} + 5'd1) >= {1'b0, ops_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= vmod_pkg::PH_IDLE;
      ops_r   <= 4'd0;
      size_r  <= 2'd0;
      form_r  <= 8'd0;
      base_r  <= 32'd0;
      seen_r  <= 3'd0;
      cur_r   <= 4'd0;
      left_r  <= 3'd0;
      acc_r   <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      ops_r   <= ops_nxt;
      size_r  <= size_nxt;
      form_r  <= form_nxt;
      base_r  <= base_nxt;
      seen_r  <= seen_nxt;
      cur_r   <= cur_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (nib_we) begin
      nib_r[{seen_r[1:0], 1'b0}] <= in_ch.code_byte[3:0] & vmod_pkg::MODE_MASK;
      nib_r[{seen_r[1:0], 1'b1}] <= in_ch.code_byte[7:4] & vmod_pkg::MODE_MASK;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    ops_nxt   = ops_r;
    size_nxt  = size_r;
    form_nxt  = form_r;
    base_nxt  = base_r;
    seen_nxt  = seen_r;
    cur_nxt   = cur_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    nib_we    = 1'b0;
    q_push    = 1'b0;

    q_job.index = cur_r[2:0];
    q_job.cls   = dec.cls;
    q_job.wsel  = dec.wsel;
    q_job.acc   = 32'd0;
    q_job.base  = base_r;
    q_job.size  = size_r;
    q_job.fault = dec.fault;
    q_job.last  = last_cur;

    if (in_fire && (in_ch.kind == vmod_pkg::KIND_START)) begin
      ops_nxt   = (in_ch.operand_count > vmod_pkg::MAX_OPERANDS) ?
                  vmod_pkg::MAX_OPERANDS : in_ch.operand_count;
      size_nxt  = (in_ch.size_code > vmod_pkg::SIZE_WORD) ?
                  vmod_pkg::SIZE_WORD : in_ch.size_code;
      form_nxt  = in_ch.store_mask;
      base_nxt  = in_ch.locals_base;
      seen_nxt  = 3'd0;
      cur_nxt   = 4'd0;
      left_nxt  = 3'd0;
      acc_nxt   = 32'd0;
      phase_nxt = (in_ch.operand_count == 4'd0) ? vmod_pkg::PH_IDLE : vmod_pkg::PH_MODES;
    end else begin
      case (phase_r)
        vmod_pkg::PH_MODES: begin
          if (in_fire) begin
            nib_we   = 1'b1;
            seen_nxt = seen_r + 3'd1;
            if (({1'b0, seen_r} + 4'd1) >= ((ops_r + 4'd1) >> 1)) begin
              phase_nxt = vmod_pkg::PH_ADV;
              left_nxt  = 3'd0;
            end
          end
        end
        vmod_pkg::PH_BYTES: begin
          if (in_fire) begin
            acc_nxt  = acc_in;
            left_nxt = left_r - 3'd1;
            if (left_r == 3'd1) begin
              q_push    = 1'b1;
              q_job.acc = acc_in;
              cur_nxt   = cur_r + 4'd1;
              phase_nxt = last_cur ? vmod_pkg::PH_IDLE : vmod_pkg::PH_ADV;
            end
          end
        end
        vmod_pkg::PH_ADV: begin
          if (cur_r >= ops_r) begin
            phase_nxt = vmod_pkg::PH_IDLE;
          end else if (k_cur != 3'd0) begin
            acc_nxt   = 32'd0;
            left_nxt  = k_cur;
            phase_nxt = vmod_pkg::PH_BYTES;
          end else if (!q_full) begin
            acc_nxt = 32'd0;
            q_push  = 1'b1;
            cur_nxt = cur_r + 4'd1;
            if (last_cur) begin
              phase_nxt = vmod_pkg::PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("descriptor pushed into a full queue");
  a_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == vmod_pkg::PH_BYTES) |-> (left_r != 3'd0))
    else $error("byte phase with no bytes outstanding");
  a_ops_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != vmod_pkg::PH_IDLE) |-> ((ops_r != 4'd0) && (ops_r <= vmod_pkg::MAX_OPERANDS)))
    else $error("open instruction with bad operand count");

endmodule
`default_nettype wire

/* rtl/core/vmod_fifo.sv */
// Two-entry descriptor queue between the front sequencer and the back end.
`default_nettype none
module vmod_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire vmod_pkg::job_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output vmod_pkg::job_t      head_data
);

  vmod_pkg::job_t          mem_r [vmod_pkg::Q_DEPTH];
  logic [vmod_pkg::Q_AW:0]   cnt_r, cnt_nxt;
  logic [vmod_pkg::Q_AW-1:0] wp_r, rp_r;
  logic                      do_push, do_pop;

  assign full       = (cnt_r == (vmod_pkg::Q_AW + 1)'(vmod_pkg::Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/vmod_back.sv */
// Back end: forms the operand word and holds the descriptor in the output register.
`default_nettype none
module vmod_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [31:0]    ram_start,
  input  wire logic           head_valid,
  input  wire vmod_pkg::job_t head_data,
  output logic                pop,
  vmod_out_if.source          out_ch
);

  logic        valid_r;
  logic [2:0]  index_r;
  logic [2:0]  cls_r;
  logic [31:0] word_r;
  logic [1:0]  size_r;
  logic [1:0]  fault_r;
  logic        last_r;
  logic [31:0] word_nxt;

  assign pop = head_valid && (!valid_r || out_ch.ready);

  always_comb begin
    case (head_data.wsel)
      vmod_pkg::W_SX8:   word_nxt = {{24{head_data.acc[7]}}, head_data.acc[7:0]};
      vmod_pkg::W_SX16:  word_nxt = {{16{head_data.acc[15]}}, head_data.acc[15:0]};
      vmod_pkg::W_RAW:   word_nxt = head_data.acc;
      vmod_pkg::W_LOCAL: word_nxt = head_data.acc + head_data.base;
      vmod_pkg::W_RAM:   word_nxt = head_data.acc + ram_start;
      default:           word_nxt = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      index_r <= head_data.index;
      cls_r   <= head_data.cls;
      word_r  <= word_nxt;
      size_r  <= head_data.size;
      fault_r <= head_data.fault;
      last_r  <= head_data.last;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.operand_index = index_r;
  assign out_ch.operand_class = cls_r;
  assign out_ch.operand_word  = word_r;
  assign out_ch.access_size   = size_r;
  assign out_ch.fault         = fault_r;
  assign out_ch.last          = last_r;

endmodule
`default_nettype wire

/* rtl/core/vm_operand_mode_decoder.sv */
// Operand mode decoder top level: front sequencer, descriptor queue, back end, APB register.
// A descriptor completed by a byte goes into the descriptor queue, then into the output register once that is free.
// Throughput: while the queue has room, one byte per cycle; each operand also passes through
// a front lookup state that holds the input, where operands with no bytes leave one per cycle.
// Reset: synchronous active-low rst_n clears control state, the queue and ram_start;
// the mode nibble store is not reset and is always written before it is read.
`default_nettype none
module vm_operand_mode_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  vmod_in_if.sink                            in_ch,
  vmod_out_if.source                         out_ch,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [vmod_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  logic [31:0]    ram_start_r;
  logic           q_push, q_full, q_pop, q_head_valid;
  vmod_pkg::job_t q_job, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == vmod_pkg::ADDR_RAM_START) ? ram_start_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_start_r <= 32'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == vmod_pkg::ADDR_RAM_START)) begin
      ram_start_r <= cfg_pwdata;
    end
  end

  vmod_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  vmod_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head)
  );

  vmod_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ram_start  (ram_start_r),
    .head_valid (q_head_valid),
    .head_data  (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
